FILE: rtl/core/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Types, codes and constants shared by the stable matching engine.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int MaxPeople = 8;
  localparam int IdxW      = 3;
  localparam int CntW      = 4;
  localparam int AddrW     = 2 * IdxW;
  localparam int Entries   = MaxPeople * MaxPeople;
  localparam int StepW     = 3;
  localparam int Steps     = 7;

  localparam logic [1:0] CmdLoadProp = 2'd0;
  localparam logic [1:0] CmdLoadAcc  = 2'd1;
  localparam logic [1:0] CmdRun      = 2'd2;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_POP,
    OP_CHECK,
    OP_RANK,
    OP_DECIDE,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_RUN,
    COND_FIFO_EMPTY,
    COND_EXHAUSTED,
    COND_REJECT,
    COND_NOT_LAST
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic run_fire;
    logic fifo_empty;
    logic exhausted;
    logic reject;
    logic last_fire;
  } flags_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [IdxW-1:0] person;
    logic [IdxW-1:0] position;
    logic [IdxW-1:0] choice;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] proposer;
    logic [IdxW-1:0] partner;
    logic            status;
    logic            last;
  } rsp_t;

endpackage

FILE: rtl/core/sme_sequencer.sv
// ----------------------------------------------------------------------------
// sme_sequencer
// Step counter and control store; picks the next step from branch flags.
// ----------------------------------------------------------------------------
module sme_sequencer import sme_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctl_t   ctl_o
);

  localparam ctl_t Program [Steps] = '{
    '{op: OP_IDLE,   cond: COND_NOT_RUN,    target: StepW'(0)},
    '{op: OP_INIT,   cond: COND_NEVER,      target: StepW'(0)},
    '{op: OP_POP,    cond: COND_FIFO_EMPTY, target: StepW'(6)},
    '{op: OP_CHECK,  cond: COND_EXHAUSTED,  target: StepW'(2)},
    '{op: OP_RANK,   cond: COND_REJECT,     target: StepW'(2)},
    '{op: OP_DECIDE, cond: COND_ALWAYS,     target: StepW'(2)},
    '{op: OP_EMIT,   cond: COND_NOT_LAST,   target: StepW'(6)}
  };

  logic [StepW-1:0] step_q, step_d;
  ctl_t             ctl;
  logic             take;

  assign ctl   = Program[step_q];
  assign ctl_o = ctl;

  always_comb begin
    case (ctl.cond)
      COND_NEVER:      take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_NOT_RUN:    take = !flags_i.run_fire;
      COND_FIFO_EMPTY: take = flags_i.fifo_empty;
      COND_EXHAUSTED:  take = flags_i.exhausted;
      COND_REJECT:     take = flags_i.reject;
      COND_NOT_LAST:   take = !flags_i.last_fire;
      default:         take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      step_d = ctl.target;
    end else if (step_q == StepW'(Steps - 1)) begin
      step_d = '0;
    end else begin
      step_d = step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  a_decide_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.op == OP_DECIDE |=> ctl.op == OP_POP)
    else $error("decide step did not return to pop");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < StepW'(Steps))
    else $error("step counter outside program");

endmodule

FILE: rtl/core/sme_datapath.sv
// ----------------------------------------------------------------------------
// sme_datapath
// Preference memories, free fifo and match registers driven by control words.
// ----------------------------------------------------------------------------
module sme_datapath import sme_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctl_t            ctl_i,
  output flags_t          flags_o,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_rsp_o
);

  logic [CntW-1:0] participants_q;
  logic [CntW-1:0] n_use;

  logic [IdxW-1:0] pref_mem [Entries];
  logic [IdxW-1:0] rank_mem [Entries];
  logic [Entries-1:0] present_q;
  logic [IdxW-1:0] pref_rd_q;
  logic [IdxW-1:0] rank_new_q;
  logic [IdxW-1:0] rank_old_q;

  logic [CntW-1:0] nc_q [MaxPeople];
  logic [MaxPeople-1:0] held_valid_q;
  logic [IdxW-1:0] held_q [MaxPeople];
  logic [MaxPeople-1:0] matched_q;
  logic [IdxW-1:0] partner_q [MaxPeople];

  logic [IdxW-1:0] fifo_q [MaxPeople];
  logic [IdxW-1:0] head_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] tail;

  logic [IdxW-1:0] p_q;
  logic [IdxW-1:0] e_q;
  logic            err_q;

  logic            in_fire, out_fire, last_item;
  logic [IdxW-1:0] acc;
  logic [AddrW-1:0] new_addr;
  logic            exhausted, reject, better;

  always_comb begin
    if (participants_q == '0) begin
      n_use = CntW'(1);
    end else if (participants_q > CntW'(MaxPeople)) begin
      n_use = CntW'(MaxPeople);
    end else begin
      n_use = participants_q;
    end
  end

  assign in_ready_o  = (ctl_i.op == OP_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (ctl_i.op == OP_EMIT);
  assign out_fire    = out_valid_o && out_ready_i;
  assign last_item   = ({1'b0, e_q} == n_use - CntW'(1));

  assign acc       = pref_rd_q;
  assign new_addr  = {acc, p_q};
  assign tail      = head_q + count_q[IdxW-1:0];
  assign exhausted = (nc_q[p_q] >= n_use);
  assign reject    = ({1'b0, acc} >= n_use) || !present_q[new_addr];
  assign better    = (rank_new_q < rank_old_q);

  assign flags_o.run_fire   = in_fire && (in_req_i.cmd == CmdRun);
  assign flags_o.fifo_empty = (count_q == '0);
  assign flags_o.exhausted  = exhausted;
  assign flags_o.reject     = reject;
  assign flags_o.last_fire  = out_fire && last_item;

  assign out_rsp_o.proposer = e_q;
  assign out_rsp_o.partner  = matched_q[e_q] ? partner_q[e_q] : '0;
  assign out_rsp_o.status   = err_q;
  assign out_rsp_o.last     = last_item;

  // preference and rank memories
  always_ff @(posedge clk_i) begin
    if (in_fire && in_req_i.cmd == CmdLoadProp) begin
      pref_mem[{in_req_i.person, in_req_i.position}] <= in_req_i.choice;
    end
    if (in_fire && in_req_i.cmd == CmdLoadAcc) begin
      rank_mem[{in_req_i.person, in_req_i.choice}] <= in_req_i.position;
    end
    if (ctl_i.op == OP_CHECK) begin
      pref_rd_q <= pref_mem[{p_q, nc_q[p_q][IdxW-1:0]}];
    end
    if (ctl_i.op == OP_RANK) begin
      rank_new_q <= rank_mem[new_addr];
      rank_old_q <= rank_mem[{acc, held_q[acc]}];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_INIT: begin
        for (int i = 0; i < MaxPeople; i++) begin
          fifo_q[i] <= IdxW'(i);
        end
      end
      OP_POP: begin
        p_q <= fifo_q[head_q];
      end
      OP_RANK: begin
        if (reject && count_q < CntW'(MaxPeople)) begin
          fifo_q[tail] <= p_q;
        end
      end
      OP_DECIDE: begin
        if (!held_valid_q[acc]) begin
          held_q[acc]    <= p_q;
          partner_q[p_q] <= acc;
        end else if (better) begin
          if (count_q < CntW'(MaxPeople)) begin
            fifo_q[tail] <= held_q[acc];
          end
          held_q[acc]    <= p_q;
          partner_q[p_q] <= acc;
        end else if (count_q < CntW'(MaxPeople)) begin
          fifo_q[tail] <= p_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      participants_q <= CntW'(MaxPeople);
      present_q      <= '0;
      head_q         <= '0;
      count_q        <= '0;
      held_valid_q   <= '0;
      matched_q      <= '0;
      err_q          <= 1'b0;
      e_q            <= '0;
      for (int i = 0; i < MaxPeople; i++) begin
        nc_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        participants_q <= cfg_data_i;
      end
      if (in_fire && in_req_i.cmd == CmdLoadAcc) begin
        present_q[{in_req_i.person, in_req_i.choice}] <= 1'b1;
      end
      case (ctl_i.op)
        OP_INIT: begin
          head_q       <= '0;
          count_q      <= n_use;
          held_valid_q <= '0;
          matched_q    <= '0;
          err_q        <= 1'b0;
          e_q          <= '0;
          for (int i = 0; i < MaxPeople; i++) begin
            nc_q[i] <= '0;
          end
        end
        OP_POP: begin
          if (count_q != '0) begin
            head_q  <= head_q + IdxW'(1);
            count_q <= count_q - CntW'(1);
          end
        end
        OP_CHECK: begin
          if (exhausted) begin
            err_q <= 1'b1;
          end else begin
            nc_q[p_q] <= nc_q[p_q] + CntW'(1);
          end
        end
        OP_RANK: begin
          if (reject) begin
            err_q <= 1'b1;
            if (count_q < CntW'(MaxPeople)) begin
              count_q <= count_q + CntW'(1);
            end
          end
        end
        OP_DECIDE: begin
          if (!held_valid_q[acc]) begin
            held_valid_q[acc] <= 1'b1;
            matched_q[p_q]    <= 1'b1;
          end else begin
            if (count_q < CntW'(MaxPeople)) begin
              count_q <= count_q + CntW'(1);
            end
            if (better) begin
              matched_q[held_q[acc]] <= 1'b0;
              matched_q[p_q]         <= 1'b1;
            end
          end
        end
        OP_EMIT: begin
          if (out_fire) begin
            e_q <= e_q + IdxW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPeople))
    else $error("free fifo count above capacity");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_POP && count_q != '0) |=> count_q == $past(count_q) - CntW'(1))
    else $error("pop did not reduce fifo count");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_item) |=> in_ready_o)
    else $error("engine not idle after final result");

endmodule

FILE: rtl/core/stable_matching_engine.sv
// ----------------------------------------------------------------------------
// stable_matching_engine
// Gale-Shapley proposer-optimal matching run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// load requests are accepted while idle; the block stays ready after each one
// a run: accept and init, then per proposal pop, check, rank read and decide
// (rejects skip decide), pop and check per exhausted proposer and a final
// pop on an empty fifo, at most n*n proposals; then n results, which may stall
// reset: participants 8, acceptor ranks all absent, proposer lists undefined
// until written; no clearing pass is needed
module stable_matching_engine import sme_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_rsp_o
);

  ctl_t   ctl;
  flags_t flags;

  sme_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  sme_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .flags_o     (flags),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives load and run requests into the stable matching engine with bursty
// request traffic and a stalling result side. Every accepted request is
// applied to a local deferred-acceptance predictor, and each returned result
// is compared field by field with the oldest predicted one. A short directed
// table opens the run, followed by random preference sets over several
// participant counts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sme_pkg::*;

  localparam logic [1:0] CmdIgnored       = 2'd3;
  localparam logic       StatusOk         = 1'b0;
  localparam logic       StatusIncomplete = 1'b1;
  localparam int         RandItems        = 470;
  localparam int         SettleCycles     = 12;
  localparam int         QuietLimit       = 4000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_PERIODIC,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  typedef struct {
    bit              is_cfg;
    logic [CntW-1:0] cfg_val;
    req_t            req;
    bit              has_want;
    rsp_t            want;
  } plan_row_t;

  logic            clk_i;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CntW-1:0] cfg_data_i  = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  req_t            in_req_i    = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  rsp_t            out_rsp_o;

  stable_matching_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // predictor state
  logic [CntW-1:0] seats = 4'd8;
  logic [IdxW-1:0] pref_of     [MaxPeople][MaxPeople];
  bit              pref_loaded [MaxPeople][MaxPeople];
  logic [IdxW-1:0] rank_of     [MaxPeople][MaxPeople];
  bit              rank_known  [MaxPeople][MaxPeople];

  rsp_t      pending_matches[$];
  plan_row_t directed_plan[$];
  rsp_t      head_match;
  int        errors       = 0;
  int        quiet_cycles = 0;
  int        items_sent   = 0;
  int        burst_left   = 0;
  int        rx_cyc       = 0;
  int        rx_left      = 0;
  int        rx_period    = 2;
  rx_mode_e  rx_mode      = RX_OPEN;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int people_active(logic [CntW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxPeople) return MaxPeople;
    return int'(v);
  endfunction

  function automatic void apply_request(req_t r, output rsp_t res[$]);
    int   n;
    int   p;
    int   a;
    int   rk;
    int   partner;
    int   nxt   [MaxPeople];
    int   held  [MaxPeople];
    bit   taken [MaxPeople];
    int   free_q[$];
    logic err;
    res = {};
    case (r.cmd)
      CmdLoadProp: begin
        pref_of[r.person][r.position]     = r.choice;
        pref_loaded[r.person][r.position] = 1'b1;
      end
      CmdLoadAcc: begin
        rank_of[r.person][r.choice]    = r.position;
        rank_known[r.person][r.choice] = 1'b1;
      end
      CmdRun: begin
        n   = people_active(seats);
        err = StatusOk;
        for (p = 0; p < MaxPeople; p++) begin
          nxt[p]   = 0;
          held[p]  = 0;
          taken[p] = 1'b0;
        end
        for (p = 0; p < n; p++) free_q.push_back(p);
        while (free_q.size() > 0) begin
          p = free_q.pop_front();
          if (nxt[p] >= n) begin
            err = StatusIncomplete;
            continue;
          end
          a = pref_of[p][nxt[p]];
          nxt[p]++;
          if (a >= n || !rank_known[a][p]) begin
            err = StatusIncomplete;
            free_q.push_back(p);
            continue;
          end
          rk = rank_of[a][p];
          if (!taken[a]) begin
            taken[a] = 1'b1;
            held[a]  = p;
          end else if (rk < rank_of[a][held[a]]) begin
            free_q.push_back(held[a]);
            held[a] = p;
          end else begin
            free_q.push_back(p);
          end
        end
        for (p = 0; p < n; p++) begin
          partner = 0;
          for (a = 0; a < n; a++) begin
            if (taken[a] && held[a] == p) partner = a;
          end
          res.push_back(rsp_t'{IdxW'(p), IdxW'(partner), err, 1'(p == n - 1)});
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void random_order(int n, output int ord[MaxPeople]);
    int i;
    int j;
    int t;
    for (i = 0; i < MaxPeople; i++) ord[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      t      = ord[i];
      ord[i] = ord[j];
      ord[j] = t;
    end
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic send_req(req_t r, bit has_want, rsp_t want);
    rsp_t res[$];
    int   gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      gap        = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(r, res);
    if (has_want) pending_matches.push_back(want);
    else foreach (res[i]) pending_matches.push_back(res[i]);
    if (r.cmd != CmdIgnored) items_sent++;
  endtask

  task automatic write_cfg(logic [CntW-1:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    seats = v;
  endtask

  // every proposer entry a run can reach is loaded before the run
  task automatic issue_run();
    int n;
    int p;
    int k;
    n = people_active(seats);
    for (p = 0; p < n; p++) begin
      for (k = 0; k < n; k++) begin
        if (!pref_loaded[p][k])
          send_req(req_t'{CmdLoadProp, IdxW'(p), IdxW'(k), IdxW'($urandom_range(0, n - 1))},
                   1'b0, '0);
      end
    end
    send_req(req_t'{CmdRun, IdxW'($urandom_range(0, 7)), IdxW'($urandom_range(0, 7)),
                    IdxW'($urandom_range(0, 7))}, 1'b0, '0);
  endtask

  task automatic send_sequence(int n, bit broken);
    req_t batch[$];
    req_t r;
    req_t t;
    int   ord[MaxPeople];
    int   p;
    int   k;
    int   i;
    int   j;
    for (p = 0; p < n; p++) begin
      random_order(n, ord);
      for (k = 0; k < n; k++) begin
        r = req_t'{CmdLoadProp, IdxW'(p), IdxW'(k), IdxW'(ord[k])};
        if (broken && $urandom_range(0, 9) == 0) r.choice = IdxW'($urandom_range(0, 7));
        batch.push_back(r);
      end
    end
    for (p = 0; p < n; p++) begin
      random_order(n, ord);
      for (k = 0; k < n; k++) begin
        r = req_t'{CmdLoadAcc, IdxW'(p), IdxW'(k), IdxW'(ord[k])};
        if (broken && $urandom_range(0, 5) == 1) r.choice = IdxW'($urandom_range(0, 7));
        if (!(broken && $urandom_range(0, 5) == 0)) batch.push_back(r);
      end
    end
    if ($urandom_range(0, 2) == 0)
      batch.push_back(req_t'{CmdIgnored, IdxW'($urandom_range(0, 7)),
                             IdxW'($urandom_range(0, 7)), IdxW'($urandom_range(0, 7))});
    for (i = batch.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = batch[i];
      batch[i] = batch[j];
      batch[j] = t;
    end
    foreach (batch[i]) send_req(batch[i], 1'b0, '0);
    issue_run();
  endtask

  task automatic send_tweaks();
    req_t r;
    int   cnt;
    cnt = $urandom_range(1, 5);
    repeat (cnt) begin
      r = req_t'{2'($urandom_range(0, 3)), IdxW'($urandom_range(0, 7)),
                 IdxW'($urandom_range(0, 7)), IdxW'($urandom_range(0, 7))};
      if (r.cmd == CmdRun) issue_run();
      else send_req(r, 1'b0, '0);
    end
    issue_run();
  endtask

  function automatic void cfg_row(logic [CntW-1:0] v);
    directed_plan.push_back('{1'b1, v, '0, 1'b0, '0});
  endfunction

  function automatic void req_row(logic [1:0] cmd, int person, int position, int choice,
                                  bit has_want, rsp_t want);
    directed_plan.push_back('{1'b0, '0,
        req_t'{cmd, IdxW'(person), IdxW'(position), IdxW'(choice)}, has_want, want});
  endfunction

  // result side stall patterns
  always @(negedge clk_i) begin
    rx_cyc++;
    if (rx_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      rx_left   = $urandom_range(30, 300);
      rx_period = $urandom_range(2, 4);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:     out_ready_i <= 1'b1;
      RX_PERIODIC: out_ready_i <= (rx_cyc % rx_period) != 0;
      RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
      default:     out_ready_i <= (rx_cyc % 3) == 0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result, actual proposer %0d partner %0d status %0d last %0d",
                 $time, out_rsp_o.proposer, out_rsp_o.partner, out_rsp_o.status,
                 out_rsp_o.last);
        errors++;
      end else begin
        head_match = pending_matches.pop_front();
        check_field("proposer", head_match.proposer, out_rsp_o.proposer);
        check_field("partner", head_match.partner, out_rsp_o.partner);
        check_field("status", head_match.status, out_rsp_o.status);
        check_field("last", head_match.last, out_rsp_o.last);
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int              phase;
    int              s;
    int              n;
    int              nseq;
    int              pick;
    logic [CntW-1:0] v;

    // single participant: absent ranks, ignored command, choice out of use
    cfg_row(4'd1);
    req_row(CmdLoadProp, 0, 0, 0, 1'b0, '0);
    req_row(CmdRun,      0, 0, 0, 1'b1, rsp_t'{3'd0, 3'd0, StatusIncomplete, 1'b1});
    req_row(CmdLoadAcc,  0, 0, 0, 1'b0, '0);
    req_row(CmdRun,      7, 7, 7, 1'b1, rsp_t'{3'd0, 3'd0, StatusOk, 1'b1});
    req_row(CmdIgnored,  7, 7, 7, 1'b0, '0);
    req_row(CmdRun,      0, 0, 0, 1'b1, rsp_t'{3'd0, 3'd0, StatusOk, 1'b1});
    req_row(CmdLoadProp, 0, 0, 7, 1'b0, '0);
    req_row(CmdRun,      0, 0, 0, 1'b1, rsp_t'{3'd0, 3'd0, StatusIncomplete, 1'b1});
    req_row(CmdLoadProp, 7, 7, 7, 1'b0, '0);
    req_row(CmdLoadAcc,  7, 7, 7, 1'b0, '0);
    req_row(CmdLoadProp, 0, 0, 0, 1'b0, '0);
    // repeated acceptor entry moves proposer 0 to the bottom
    req_row(CmdLoadAcc,  0, 7, 0, 1'b0, '0);
    req_row(CmdRun,      0, 0, 0, 1'b1, rsp_t'{3'd0, 3'd0, StatusOk, 1'b1});
    req_row(CmdLoadAcc,  0, 0, 7, 1'b0, '0);
    req_row(CmdRun,      0, 0, 0, 1'b1, rsp_t'{3'd0, 3'd0, StatusOk, 1'b1});
    // two participants with a rank tie at acceptor 0
    cfg_row(4'd2);
    req_row(CmdLoadProp, 0, 1, 1, 1'b0, '0);
    req_row(CmdLoadProp, 1, 0, 0, 1'b0, '0);
    req_row(CmdLoadProp, 1, 1, 1, 1'b0, '0);
    req_row(CmdLoadAcc,  0, 7, 1, 1'b0, '0);
    req_row(CmdLoadAcc,  1, 0, 0, 1'b0, '0);
    req_row(CmdLoadAcc,  1, 1, 1, 1'b0, '0);
    req_row(CmdRun,      0, 0, 0, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) write_cfg(directed_plan[i].cfg_val);
      else send_req(directed_plan[i].req, directed_plan[i].has_want, directed_plan[i].want);
    end

    items_sent = 0;
    phase      = 0;
    while (items_sent < RandItems) begin
      case (phase)
        0: v = 4'd15;
        1: v = 4'd0;
        2: v = 4'd8;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) v = 4'd1;
          else if (pick == 1) v = CntW'($urandom_range(5, 7));
          else if (pick == 2) v = CntW'($urandom_range(8, 15));
          else v = CntW'($urandom_range(2, 4));
        end
      endcase
      write_cfg(v);
      n    = people_active(v);
      nseq = $urandom_range(2, 4);
      for (s = 0; s < nseq && items_sent < RandItems; s++) begin
        if (phase == 0 && s == 0) send_sequence(n, 1'b0);
        else if (n >= 6) send_tweaks();
        else begin
          pick = $urandom_range(0, 9);
          if (pick < 6) send_sequence(n, 1'b0);
          else if (pick < 8) send_sequence(n, 1'b1);
          else send_tweaks();
        end
      end
      phase++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
